/* rtl/kts_pkg.sv */
// shared types, field widths and codes for the strength-sorted device table
package kts_pkg;

	localparam int OP_W   = 2;
	localparam int ADDR_W = 48;
	localparam int KIND_W = 2;
	localparam int STR_W  = 8;
	localparam int RANK_W = 5;
	localparam int POS_W  = 5;
	localparam int HELD_W = 6;
	localparam int CAP_W  = 6;

	localparam int MAX_ENTRIES_DEF = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd30;

	localparam logic [OP_W-1:0] OP_REPORT = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          opcode;
		logic [ADDR_W-1:0]        device_address;
		logic [KIND_W-1:0]        address_kind;
		logic signed [STR_W-1:0]  signal_strength;
		logic [RANK_W-1:0]        rank_index;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]         position;
		logic [HELD_W-1:0]        entries_held;
		logic                     was_new;
		logic                     dropped;
		logic                     read_valid;
		logic [ADDR_W-1:0]        read_address;
		logic [KIND_W-1:0]        read_address_kind;
		logic signed [STR_W-1:0]  read_strength;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]        address;
		logic [KIND_W-1:0]        kind;
		logic signed [STR_W-1:0]  strength;
	} entry_t;

	typedef enum logic [2:0] {
		MODE_HOLD,
		MODE_INIT,
		MODE_SCAN,
		MODE_APPLY,
		MODE_ROTATE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		entry_t     ins;
	} cell_ctl_t;

endpackage

/* rtl/keyed_table_sorted_by_signal.sv */
// top level of the strength-sorted device table with its request sequencer
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  kts_pkg::req_t
//  rsp      out        rsp_valid / rsp_stall  kts_pkg::rsp_t
//  cfg      in         cfg_valid / cfg_ready  capacity_in_use, 6 bits
//
// report: the search wave walks one cell per cycle in the scan state, then an apply
// step (skipped when dropped), then the finish state loads the result
// read: one full rotation of the row past cell 0, then the finish state;
// clear and the unused code go straight to finish; then idle before the next request
// reset empties the table (count 0) and sets the capacity to 30; no clearing pass
// a result waits in its own register; a new request is taken meanwhile and is only
// held in its last cycle while that register is still full
module keyed_table_sorted_by_signal #(
	parameter int MAX_ENTRIES = kts_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  kts_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output kts_pkg::rsp_t              rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [kts_pkg::CAP_W-1:0]  cfg_data
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int SC_W  = $clog2(MAX_ENTRIES);
	// common width for count, capacity and rank compares
	localparam int CMP_W = (CNT_W > kts_pkg::CAP_W) ? CNT_W : kts_pkg::CAP_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_ROTATE,
		S_FINISH
	} state_t;

	state_t                      state_q;
	logic [SC_W-1:0]             sc_q;
	logic [CNT_W-1:0]            count_q;
	logic [kts_pkg::CAP_W-1:0]   cap_q;
	kts_pkg::req_t               req_q;
	kts_pkg::rsp_t               wrk_q;
	kts_pkg::rsp_t               rsp_q;
	logic                        rsp_valid_q;

	kts_pkg::cell_ctl_t          ctl;
	logic                        last_sm;
	logic [CNT_W-1:0]            last_cnt;
	logic [kts_pkg::KIND_W-1:0]  last_mk;
	kts_pkg::entry_t             head;

	logic                        found;
	logic                        drop;
	logic                        sc_last;
	logic                        out_free;
	logic                        rank_hit;
	logic [CMP_W-1:0]            cap_x;
	logic [CMP_W-1:0]            cap_eff;
	kts_pkg::rsp_t               fin_rsp;

	// capacity register, written only while idle with no request offered
	assign cfg_ready = (state_q == S_IDLE) && !req_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= kts_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// zero acts as one, above the row size acts as the row size
	assign cap_x = CMP_W'(cap_q);
	always_comb begin
		priority if (cap_x == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_x > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_x;
		end
	end

	// after the wave has passed the last cell its outputs cover the whole row
	assign found   = last_sm;
	assign drop    = !found && (CMP_W'(count_q) >= cap_eff);
	assign sc_last = sc_q == SC_W'(MAX_ENTRIES - 1);
	assign out_free = !rsp_valid_q || !rsp_stall;

	// during rotation cell 0 holds rank sc_q of the table
	assign rank_hit = (CMP_W'(sc_q) == CMP_W'(req_q.rank_index)) &&
		(CMP_W'(req_q.rank_index) < CMP_W'(count_q));

	// finished result with the entry count after this request
	always_comb begin
		fin_rsp              = wrk_q;
		fin_rsp.entries_held = kts_pkg::HELD_W'(count_q);
	end

	// broadcast to every cell: the reported entry, keeping the old kind on a hit
	always_comb begin
		ctl.ins.address  = req_q.device_address;
		ctl.ins.kind     = found ? last_mk : req_q.address_kind;
		ctl.ins.strength = req_q.signal_strength;
		unique case (state_q)
			S_IDLE:   ctl.mode = kts_pkg::MODE_INIT;
			S_SCAN:   ctl.mode = kts_pkg::MODE_SCAN;
			S_APPLY:  ctl.mode = kts_pkg::MODE_APPLY;
			S_ROTATE: ctl.mode = kts_pkg::MODE_ROTATE;
			default:  ctl.mode = kts_pkg::MODE_HOLD;
		endcase
	end

	kts_row #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.CNT_W       (CNT_W)
	) u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.count    (count_q),
		.last_sm  (last_sm),
		.last_cnt (last_cnt),
		.last_mk  (last_mk),
		.head     (head)
	);

	// request sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sc_q        <= '0;
			count_q     <= '0;
			req_q       <= '0;
			wrk_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// result register refills from the sequencer, empties on acceptance
			if (state_q == S_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						wrk_q <= '0;
						sc_q  <= '0;
						unique case (req.opcode)
							kts_pkg::OP_REPORT: state_q <= S_SCAN;
							kts_pkg::OP_READ:   state_q <= S_ROTATE;
							kts_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_FINISH;
							end
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_SCAN: begin
					sc_q <= sc_q + SC_W'(1);
					if (sc_last) begin
						wrk_q.dropped  <= drop;
						wrk_q.was_new  <= !found && !drop;
						wrk_q.position <= drop ? '0 : kts_pkg::POS_W'(last_cnt);
						state_q        <= drop ? S_FINISH : S_APPLY;
					end
				end
				S_APPLY: begin
					if (wrk_q.was_new) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_FINISH;
				end
				S_ROTATE: begin
					sc_q <= sc_q + SC_W'(1);
					if (rank_hit) begin
						wrk_q.read_valid        <= 1'b1;
						wrk_q.read_address      <= head.address;
						wrk_q.read_address_kind <= head.kind;
						wrk_q.read_strength     <= head.strength;
					end
					if (sc_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						rsp_q   <= fin_rsp;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// table never holds more entries than the row has cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond row size");

	// an accepted request always leaves the sequencer busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted without going busy");

	// a report either adds an entry or is dropped, never both
	a_new_or_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.was_new && rsp.dropped))
		else $error("result both new and dropped");

	// count only grows by one or is cleared
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CNT_W'(1)) || (count_q == '0)))
		else $error("entry count changed by an illegal step");

endmodule

/* rtl/kts_cell.sv */
// one table slot: stored entry, search wave registers and neighbor shift logic
module kts_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kts_pkg::cell_ctl_t          ctl,
	input  logic [CNT_W-1:0]            count,
	input  logic                        prev_sm,
	input  logic [CNT_W-1:0]            prev_cnt,
	input  logic                        prev_cb,
	input  kts_pkg::entry_t             prev_c,
	input  logic [kts_pkg::KIND_W-1:0]  prev_mk,
	input  logic                        next_b,
	input  kts_pkg::entry_t             next_ent,
	output kts_pkg::entry_t             ent,
	output logic                        b,
	output logic                        sm,
	output logic [CNT_W-1:0]            cnt_out,
	output logic                        cb,
	output kts_pkg::entry_t             c,
	output logic [kts_pkg::KIND_W-1:0]  mk
);

	kts_pkg::entry_t             ent_q;
	logic                        seen_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [kts_pkg::KIND_W-1:0]  mk_q;
	logic                        valid;
	logic                        match;

	assign valid = CNT_W'(IDX) < count;
	assign match = valid && (ent_q.address == ctl.ins.address);

	// entry ends up ahead of the reported one
	assign b = valid && !match &&
		((ent_q.strength > ctl.ins.strength) ||
		 ((ent_q.strength == ctl.ins.strength) && !seen_q));

	assign sm      = seen_q | match;
	assign cnt_out = cnt_q + CNT_W'(b);
	assign mk      = match ? ent_q.kind : mk_q;

	// view of the table with the matched entry taken out
	assign cb  = sm ? next_b : b;
	assign c   = sm ? next_ent : ent_q;
	assign ent = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			cnt_q  <= '0;
			mk_q   <= '0;
		end else begin
			unique case (ctl.mode)
				kts_pkg::MODE_INIT: begin
					seen_q <= 1'b0;
					cnt_q  <= '0;
					mk_q   <= '0;
				end
				kts_pkg::MODE_SCAN: begin
					seen_q <= prev_sm;
					cnt_q  <= prev_cnt;
					mk_q   <= prev_mk;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mode == kts_pkg::MODE_APPLY) begin
			ent_q <= cb ? c : (prev_cb ? ctl.ins : prev_c);
		end else if (ctl.mode == kts_pkg::MODE_ROTATE) begin
			ent_q <= next_ent;
		end
	end

endmodule

/* rtl/kts_row.sv */
// row of table cells chained to their neighbors
module kts_row #(
	parameter int MAX_ENTRIES = kts_pkg::MAX_ENTRIES_DEF,
	parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kts_pkg::cell_ctl_t          ctl,
	input  logic [CNT_W-1:0]            count,
	output logic                        last_sm,
	output logic [CNT_W-1:0]            last_cnt,
	output logic [kts_pkg::KIND_W-1:0]  last_mk,
	output kts_pkg::entry_t             head
);

	kts_pkg::entry_t             ent_w [MAX_ENTRIES];
	kts_pkg::entry_t             c_w   [MAX_ENTRIES];
	logic [CNT_W-1:0]            cnt_w [MAX_ENTRIES];
	logic [kts_pkg::KIND_W-1:0]  mk_w  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]      b_w;
	logic [MAX_ENTRIES-1:0]      sm_w;
	logic [MAX_ENTRIES-1:0]      cb_w;

	for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
		logic                        p_sm;
		logic [CNT_W-1:0]            p_cnt;
		logic                        p_cb;
		kts_pkg::entry_t             p_c;
		logic [kts_pkg::KIND_W-1:0]  p_mk;
		logic                        n_b;
		kts_pkg::entry_t             n_ent;

		if (gi == 0) begin : g_first
			assign p_sm  = 1'b0;
			assign p_cnt = '0;
			assign p_cb  = 1'b1;
			assign p_c   = '0;
			assign p_mk  = '0;
		end else begin : g_mid
			assign p_sm  = sm_w[gi-1];
			assign p_cnt = cnt_w[gi-1];
			assign p_cb  = cb_w[gi-1];
			assign p_c   = c_w[gi-1];
			assign p_mk  = mk_w[gi-1];
		end

		// last cell wraps to the head for rotation
		if (gi == MAX_ENTRIES - 1) begin : g_last
			assign n_b   = 1'b0;
			assign n_ent = ent_w[0];
		end else begin : g_inner
			assign n_b   = b_w[gi+1];
			assign n_ent = ent_w[gi+1];
		end

		kts_cell #(
			.IDX   (gi),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.count    (count),
			.prev_sm  (p_sm),
			.prev_cnt (p_cnt),
			.prev_cb  (p_cb),
			.prev_c   (p_c),
			.prev_mk  (p_mk),
			.next_b   (n_b),
			.next_ent (n_ent),
			.ent      (ent_w[gi]),
			.b        (b_w[gi]),
			.sm       (sm_w[gi]),
			.cnt_out  (cnt_w[gi]),
			.cb       (cb_w[gi]),
			.c        (c_w[gi]),
			.mk       (mk_w[gi])
		);
	end

	assign last_sm  = sm_w[MAX_ENTRIES-1];
	assign last_cnt = cnt_w[MAX_ENTRIES-1];
	assign last_mk  = mk_w[MAX_ENTRIES-1];
	assign head     = ent_w[0];

endmodule

/* sim/tb_keyed_table_sorted_by_signal.sv */
// testbench for the strength-sorted device table: queued stimulus, in-line table predictor
`timescale 1ns / 100ps

module tb_keyed_table_sorted_by_signal;

	import kts_pkg::*;

	// table depth of the instance under test
	localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
	// opcode that the block must ignore
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	// addresses that random reports mostly pick from, so that updates happen
	localparam int POOL_SIZE = 40;
	// receiver hold long enough to back the block up into its request side
	localparam int HOLD_CYCLES = 400;
	// extra wait at the end, sized from the table depth to cover any tail
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
	// cycles without any handshake before the run is called hung
	localparam int WATCHDOG_LIMIT = 4000;
	// strengths that random reports reuse to create ties
	localparam logic [3:0][STR_W-1:0] TIE_LEVELS = {8'h80, 8'h7f, 8'h00, 8'hc4};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	// stimulus waiting to be offered, and results predicted but not yet seen
	req_t request_queue [$];
	rsp_t awaited_results [$];

	// predictor copy of the table and its capacity register
	entry_t rows [TABLE_DEPTH];
	int held_rows = 0;
	logic [CAP_W-1:0] cap_setting = CAP_RESET;

	logic [ADDR_W-1:0] address_pool [POOL_SIZE];

	// knobs the stimulus sequence sets per phase
	int idle_pct = 25;
	int clear_pct = 2;
	bit hold_request = 1'b0;

	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_served = 1'b0;
	int fail_count = 0;
	int quiet_cycles = 0;

	keyed_table_sorted_by_signal #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// table predictor
	// ---------------------------------------------------------------

	// rank of an address among the live rows, -1 when absent
	function automatic int find_row(logic [ADDR_W-1:0] addr);
		int found;
		found = -1;
		for (int i = held_rows - 1; i >= 0; i--) begin
			if (rows[i].address == addr)
				found = i;
		end
		return found;
	endfunction

	// insertion sort, strongest first; equal strengths keep their order
	function automatic void resort_rows();
		entry_t moving;
		int j;
		for (int i = 1; i < held_rows; i++) begin
			moving = rows[i];
			j = i;
			while (j > 0 && $signed(rows[j-1].strength) < $signed(moving.strength)) begin
				rows[j] = rows[j-1];
				j--;
			end
			rows[j] = moving;
		end
	endfunction

	// applies one request to the predicted table and returns the result it owes
	function automatic rsp_t table_response(req_t r);
		rsp_t o;
		int slot;
		int limit;
		o = '0;
		case (r.opcode)
			OP_REPORT: begin
				slot = find_row(r.device_address);
				if (slot < 0) begin
					// zero acts as one, anything past the depth as the depth
					limit = int'(cap_setting);
					if (limit < 1)
						limit = 1;
					if (limit > TABLE_DEPTH)
						limit = TABLE_DEPTH;
					if (held_rows >= limit) begin
						o.dropped = 1'b1;
					end else begin
						slot = held_rows;
						rows[slot].address = r.device_address;
						rows[slot].kind = r.address_kind;
						held_rows++;
						o.was_new = 1'b1;
					end
				end
				if (slot >= 0) begin
					rows[slot].strength = r.signal_strength;
					resort_rows();
					o.position = POS_W'(find_row(r.device_address));
				end
			end
			OP_CLEAR: begin
				held_rows = 0;
			end
			OP_READ: begin
				// ranks past the count never show stale rows
				if (int'(r.rank_index) < held_rows) begin
					o.read_valid = 1'b1;
					o.read_address = rows[r.rank_index].address;
					o.read_address_kind = rows[r.rank_index].kind;
					o.read_strength = rows[r.rank_index].strength;
				end
			end
			default: begin
			end
		endcase
		o.entries_held = HELD_W'(held_rows);
		return o;
	endfunction

	// ---------------------------------------------------------------
	// stimulus builders
	// ---------------------------------------------------------------

	function automatic req_t make_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
			logic [KIND_W-1:0] kind, logic [STR_W-1:0] level, logic [RANK_W-1:0] rank);
		req_t r;
		r.opcode = op;
		r.device_address = addr;
		r.address_kind = kind;
		r.signal_strength = level;
		r.rank_index = rank;
		return r;
	endfunction

	// mostly pooled addresses, some fresh ones; all fields random even where unused
	function automatic req_t random_request();
		req_t r;
		logic [63:0] wide;
		int pick;
		wide = {$urandom(), $urandom()};
		if ($urandom_range(0, 99) < 80)
			r.device_address = address_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			r.device_address = wide[ADDR_W-1:0];
		r.address_kind = KIND_W'($urandom());
		if ($urandom_range(0, 4) == 0)
			r.signal_strength = TIE_LEVELS[$urandom_range(0, 3)];
		else
			r.signal_strength = STR_W'($urandom());
		// half the reads aim at the low ranks that are usually filled
		if ($urandom_range(0, 1) == 0)
			r.rank_index = RANK_W'($urandom_range(0, 7));
		else
			r.rank_index = RANK_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < clear_pct)
			r.opcode = OP_CLEAR;
		else if (pick < clear_pct + 2)
			r.opcode = OP_UNUSED;
		else if (pick < clear_pct + 35)
			r.opcode = OP_READ;
		else
			r.opcode = OP_REPORT;
		return r;
	endfunction

	// sender stays quiet until every predicted result has come back
	task automatic wait_until_drained();
		do @(negedge clk);
		while (request_queue.size() != 0 || req_valid || awaited_results.size() != 0);
	endtask

	// one phase: drain, set capacity, then queue an optional fill and random requests
	task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle, input int clears,
			input int count, input int fill, input bit hold);
		wait_until_drained();
		@(posedge clk);
		cfg_data <= cap;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_setting = cap;
		idle_pct = idle;
		clear_pct = clears;
		if (hold)
			hold_request = 1'b1;
		// fill from the pool so later random reports update these rows
		if (fill != 0) begin
			request_queue.push_back(make_req(OP_CLEAR, '0, '0, '0, '0));
			for (int i = 0; i < fill; i++)
				request_queue.push_back(make_req(OP_REPORT, address_pool[i % POOL_SIZE],
					KIND_W'($urandom()), STR_W'($urandom()), RANK_W'($urandom())));
		end
		repeat (count) request_queue.push_back(random_request());
	endtask

	// ---------------------------------------------------------------
	// request driver
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap <= 0;
		end else begin
			// predict at acceptance, in request order
			if (req_valid && !req_stall)
				awaited_results.push_back(table_response(req));
			if (req_valid && req_stall) begin
				// stalled request holds its payload
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				send_gap <= $urandom_range(0, 11);
				req_valid <= 1'b0;
			end else if (request_queue.size() != 0) begin
				req <= request_queue.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor and receiver stall
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result with nothing awaited: pos %0d held %0d", rsp.position,
							rsp.entries_held);
				end else begin
					want = awaited_results.pop_front();
					if (rsp.position !== want.position || rsp.entries_held !== want.entries_held
							|| rsp.was_new !== want.was_new || rsp.dropped !== want.dropped
							|| rsp.read_valid !== want.read_valid
							|| rsp.read_address !== want.read_address
							|| rsp.read_address_kind !== want.read_address_kind
							|| rsp.read_strength !== want.read_strength) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch exp: pos %0d held %0d new %b drop %b rv %b addr %h k %0d s %0d",
								want.position, want.entries_held, want.was_new, want.dropped,
								want.read_valid, want.read_address, want.read_address_kind,
								want.read_strength);
							$display("         got: pos %0d held %0d new %b drop %b rv %b addr %h k %0d s %0d",
								rsp.position, rsp.entries_held, rsp.was_new, rsp.dropped,
								rsp.read_valid, rsp.read_address, rsp.read_address_kind,
								rsp.read_strength);
						end
					end
				end
			end
			// one long hold first when asked, otherwise short random bursts
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else if (hold_request && !hold_served) begin
				hold_served <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				rsp_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				rsp_stall <= 1'b1;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left <= $urandom_range(0, 11);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: cycles with no handshake on any channel
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// stimulus sequence
	// ---------------------------------------------------------------

	initial begin
		logic [63:0] wide;
		// pool holds the address extremes and random keys
		address_pool[0] = '0;
		address_pool[1] = '1;
		address_pool[2] = 48'h8000_0000_0000;
		address_pool[3] = 48'h7fff_ffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++) begin
			wide = {$urandom(), $urandom()};
			address_pool[i] = wide[ADDR_W-1:0];
		end

		// directed part at the reset capacity
		// empty table: read and the unused code
		request_queue.push_back(make_req(OP_READ, '0, '0, '0, 5'd0));
		request_queue.push_back(make_req(OP_UNUSED, '0, '0, '0, '0));
		// new rows at the strength and address extremes
		request_queue.push_back(make_req(OP_REPORT, 48'h0, 2'd0, 8'h00, '0));
		request_queue.push_back(make_req(OP_REPORT, 48'hffff_ffff_ffff, 2'd3, 8'h7f, '0));
		request_queue.push_back(make_req(OP_REPORT, 48'h8000_0000_0000, 2'd2, 8'h80, '0));
		// equal strengths keep arrival order
		request_queue.push_back(make_req(OP_REPORT, 48'h5555_5555_5555, 2'd1, 8'h00, '0));
		request_queue.push_back(make_req(OP_REPORT, 48'haaaa_aaaa_aaaa, 2'd2, 8'h7f, '0));
		// updates of held rows; the kind of an existing row stays
		request_queue.push_back(make_req(OP_REPORT, 48'h0, 2'd3, 8'h80, '0));
		request_queue.push_back(make_req(OP_REPORT, 48'h5555_5555_5555, 2'd0, 8'h7f, '0));
		// every filled rank, the first empty one and the top rank
		for (int i = 0; i < 6; i++)
			request_queue.push_back(make_req(OP_READ, '0, '0, '0, RANK_W'(i)));
		request_queue.push_back(make_req(OP_READ, '1, '1, '1, 5'd31));
		// unused code with every field set
		request_queue.push_back(make_req(OP_UNUSED, '1, '1, '1, '1));
		// clear, then stale rows must stay hidden
		request_queue.push_back(make_req(OP_CLEAR, '1, '1, '1, '1));
		request_queue.push_back(make_req(OP_READ, '0, '0, '0, 5'd0));
		request_queue.push_back(make_req(OP_REPORT, 48'hffff_ffff_ffff, 2'd1, 8'hff, '0));
		request_queue.push_back(make_req(OP_READ, '0, '0, '0, 5'd0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// capacity one and zero (zero acts as one)
		run_phase(6'd1, 25, 3, 120, 0, 1'b0);
		run_phase(6'd0, 25, 3, 120, 0, 1'b0);
		// full depth with a fill past it and one long receiver hold
		run_phase(6'd32, 30, 0, 150, 34, 1'b1);
		// above the depth acts as the depth
		run_phase(6'd63, 20, 1, 150, 34, 1'b0);
		// hold twenty rows, then lower the capacity under the count
		run_phase(6'd30, 25, 0, 0, 20, 1'b0);
		run_phase(6'd6, 25, 0, 150, 0, 1'b0);
		run_phase(6'd2, 40, 4, 120, 0, 1'b0);
		// no idling from here to the end
		run_phase(6'd12, 0, 2, 150, 0, 1'b0);
		run_phase(6'd30, 0, 2, 240, 0, 1'b0);

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
